[rtl/hcbp_pkg.sv]
package hcbp_pkg;

   typedef enum logic [1:0] {
      KIND_PIXEL      = 2'd0,
      KIND_BM_READ    = 2'd1,
      KIND_COLOR_READ = 2'd2,
      KIND_CLEAR      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_THIRD = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [8:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [3:0]  pixel_color;
      logic [12:0] read_index;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] read_data;
   } rsp_type;

   // count is 0, 1 or 2 colors seen in the cell
   typedef struct packed {
      logic [1:0] count;
      logic [3:0] fg;
      logic [3:0] bg;
   } cell_type;

   typedef struct packed {
      logic rd_en;
      logic bm_we;
      logic cell_we;
   } store_ctl_type;

endpackage

[rtl/hcbp_store.sv]
module hcbp_store #(
   parameter int BM_DEPTH   = 8000,
   parameter int CELL_DEPTH = 1000,
   parameter int ADDR_W     = 13,
   parameter int CELL_W     = 10
) (
   input  logic                    clock,
   input  hcbp_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]       bm_rd_addr,
   input  logic [ADDR_W-1:0]       bm_wr_addr,
   input  logic [7:0]              bm_wr_data,
   input  logic [CELL_W-1:0]       cell_rd_addr,
   input  logic [CELL_W-1:0]       cell_wr_addr,
   input  hcbp_pkg::cell_type      cell_wr_data,
   output logic [7:0]              bm_rd_data,
   output hcbp_pkg::cell_type      cell_rd_data
);
   import hcbp_pkg::*;

   logic [7:0] bm_mem [BM_DEPTH];
   cell_type   cell_mem [CELL_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.bm_we) begin
         bm_mem[bm_wr_addr] <= bm_wr_data;
      end
      if (ctl.rd_en) begin
         bm_rd_data <= bm_mem[bm_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cell_we) begin
         cell_mem[cell_wr_addr] <= cell_wr_data;
      end
      if (ctl.rd_en) begin
         cell_rd_data <= cell_mem[cell_rd_addr];
      end
   end

endmodule

[rtl/hires_cell_bitmap_packer_top.sv]
// Two-color-per-cell bitmap packer.
// req channel: one item per pixel write, bitmap byte read, cell color read
// or image clear. rsp channel: one item (status, read_data) per req item.
// Both channels move an item on a clock edge with valid high and stall low.
// An item is taken in the idle state; the bitmap and cell memories are read
// at that edge, and the exec state then computes the result, writes back and
// loads the rsp register once rsp is empty or not stalled. A new item is taken
// only after that write-back (memory read, then write-back).
// The next request is taken while a result still waits in the rsp register;
// a result that is ready while rsp is stalled and full holds in place.
// Reset (synchronous, active high) and the clear kind both run a sweep that
// zeroes the memories, one bitmap byte a cycle over all CELL_COLUMNS*CELL_ROWS*8
// bytes and one cell a cycle for the first CELL_COLUMNS*CELL_ROWS steps; no item
// is taken during the sweep. The clear item's result is loaded as its sweep starts.
module hires_cell_bitmap_packer_top #(
   parameter int CELL_COLUMNS = 40,
   parameter int CELL_ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcbp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcbp_pkg::rsp_type rsp_payload
);
   import hcbp_pkg::*;

   localparam int CELL_COUNT   = CELL_COLUMNS * CELL_ROWS;
   localparam int BITMAP_BYTES = CELL_COUNT * 8;
   localparam int SCREEN_W     = CELL_COLUMNS * 8;
   localparam int SCREEN_H     = CELL_ROWS * 8;
   localparam int CELL_W       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int ADDR_W       = CELL_W + 3;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   kind_type          kind_ff;
   logic [3:0]        color_ff;
   logic [2:0]        bitpos_ff;
   logic              range_ok_ff;
   logic [ADDR_W-1:0] bm_addr_ff;
   logic [CELL_W-1:0] cell_addr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              exec_done;
   logic              sweep_last;
   logic              range_ok;
   logic [CELL_W-1:0] pix_cell;
   logic [ADDR_W-1:0] pix_addr;
   logic [ADDR_W-1:0] bm_rd_addr;
   logic [CELL_W-1:0] cell_rd_addr;
   logic [ADDR_W-1:0] bm_wr_addr;
   logic [CELL_W-1:0] cell_wr_addr;
   logic [7:0]        bm_wr_data;
   cell_type          cell_wr_data;
   logic [7:0]        bm_rd_data;
   cell_type          cell_rd_data;
   store_ctl_type     store_ctl;

   cell_type          cell_new;
   logic              as_fg;
   logic              third;
   logic [7:0]        mask;
   logic [7:0]        color_byte;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign exec_done   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign sweep_last  = (sweep_ff == ADDR_W'(BITMAP_BYTES - 1));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // request decode: addresses and range check
   always_comb begin
      pix_cell = CELL_W'(32'(req_payload.pixel_y[7:3]) * CELL_COLUMNS
                         + 32'(req_payload.pixel_x[8:3]));
      pix_addr = {pix_cell, req_payload.pixel_y[2:0]};
      unique case (req_payload.kind)
         KIND_PIXEL: begin
            range_ok = (32'(req_payload.pixel_x) < SCREEN_W)
                    && (32'(req_payload.pixel_y) < SCREEN_H);
         end
         KIND_BM_READ:    range_ok = (32'(req_payload.read_index) < BITMAP_BYTES);
         KIND_COLOR_READ: range_ok = (32'(req_payload.read_index) < CELL_COUNT);
         default:         range_ok = 1'b1;
      endcase
      if (req_payload.kind == KIND_PIXEL) begin
         bm_rd_addr   = pix_addr;
         cell_rd_addr = pix_cell;
      end else begin
         bm_rd_addr   = ADDR_W'(req_payload.read_index);
         cell_rd_addr = CELL_W'(req_payload.read_index);
      end
   end

   // pixel placement against the cell's colors
   always_comb begin
      cell_new = cell_rd_data;
      as_fg    = 1'b0;
      third    = 1'b0;
      case (cell_rd_data.count)
         2'd0: begin
            cell_new.count = 2'd1;
            cell_new.bg    = color_ff;
         end
         2'd1: begin
            if (cell_rd_data.bg != color_ff) begin
               cell_new.count = 2'd2;
               cell_new.fg    = color_ff;
               as_fg          = 1'b1;
            end
         end
         default: begin
            if (cell_rd_data.fg == color_ff) begin
               as_fg = 1'b1;
            end else if (cell_rd_data.bg != color_ff) begin
               third = 1'b1;
            end
         end
      endcase
      mask = 8'h80 >> bitpos_ff;
      color_byte = 8'h00;
      if (cell_rd_data.count != 2'd0) begin
         color_byte[3:0] = cell_rd_data.bg;
      end
      if (cell_rd_data.count > 2'd1) begin
         color_byte[7:4] = cell_rd_data.fg;
      end
   end

   // result and write-back
   always_comb begin
      rsp_in.status    = STATUS_OK;
      rsp_in.read_data = 8'h00;
      if (!range_ok_ff) begin
         rsp_in.status = STATUS_RANGE;
      end else begin
         unique case (kind_ff)
            KIND_PIXEL: begin
               if (third) begin
                  rsp_in.status = STATUS_THIRD;
               end
            end
            KIND_BM_READ:    rsp_in.read_data = bm_rd_data;
            KIND_COLOR_READ: rsp_in.read_data = color_byte;
            default:         rsp_in.read_data = 8'h00;
         endcase
      end

      store_ctl.rd_en = accept;
      if (state_ff == ST_CLEAR) begin
         store_ctl.bm_we   = 1'b1;
         store_ctl.cell_we = (32'(sweep_ff) < CELL_COUNT);
         bm_wr_addr        = sweep_ff;
         cell_wr_addr      = CELL_W'(sweep_ff);
         bm_wr_data        = 8'h00;
         cell_wr_data      = '0;
      end else begin
         store_ctl.bm_we   = exec_done && (kind_ff == KIND_PIXEL) && range_ok_ff && !third;
         store_ctl.cell_we = store_ctl.bm_we;
         bm_wr_addr        = bm_addr_ff;
         cell_wr_addr      = cell_addr_ff;
         bm_wr_data        = as_fg ? (bm_rd_data | mask) : (bm_rd_data & ~mask);
         cell_wr_data      = cell_new;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // write-back lands before the next read, so no forwarding
            if (exec_done) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_CLEAR) begin
                  state_in = ST_CLEAR;
                  sweep_in = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req_payload.kind;
         color_ff     <= req_payload.pixel_color;
         bitpos_ff    <= req_payload.pixel_x[2:0];
         range_ok_ff  <= range_ok;
         bm_addr_ff   <= pix_addr;
         cell_addr_ff <= pix_cell;
      end
      if (exec_done) begin
         rsp_ff <= rsp_in;
      end
   end

   hcbp_store #(
      .BM_DEPTH   (BITMAP_BYTES),
      .CELL_DEPTH (CELL_COUNT),
      .ADDR_W     (ADDR_W),
      .CELL_W     (CELL_W)
   ) u_store (
      .clock        (clock),
      .ctl          (store_ctl),
      .bm_rd_addr   (bm_rd_addr),
      .bm_wr_addr   (bm_wr_addr),
      .bm_wr_data   (bm_wr_data),
      .cell_rd_addr (cell_rd_addr),
      .cell_wr_addr (cell_wr_addr),
      .cell_wr_data (cell_wr_data),
      .bm_rd_data   (bm_rd_data),
      .cell_rd_data (cell_rd_data)
   );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import hcbp_pkg::*;

   localparam int COLS      = 40;
   localparam int ROWS      = 25;
   localparam int CELLS     = COLS * ROWS;
   localparam int BM_BYTES  = CELLS * 8;
   localparam int SCR_W     = COLS * 8;
   localparam int SCR_H     = ROWS * 8;
   localparam int HOT_CELLS = 6;
   localparam int HOLD_LEN  = 400;
   localparam int WDOG_MAX  = 30000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   hires_cell_bitmap_packer_top #(
      .CELL_COLUMNS(COLS),
      .CELL_ROWS   (ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow image and per-cell colors
   logic [7:0] bm_img   [BM_BYTES];
   logic [1:0] cell_cnt [CELLS];
   logic [3:0] cell_bg  [CELLS];
   logic [3:0] cell_fg  [CELLS];

   rsp_type rsp_awaited[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;
   bit      hold_off_req = 1'b0;

   int         hot_col [HOT_CELLS];
   int         hot_row [HOT_CELLS];
   logic [3:0] hot_pal [HOT_CELLS][3];

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic void wipe_image();
      foreach (bm_img[a]) bm_img[a] = '0;
      foreach (cell_cnt[c]) begin
         cell_cnt[c] = '0;
         cell_bg[c]  = '0;
         cell_fg[c]  = '0;
      end
   endfunction

   // apply one item to the shadow state and return its response
   function automatic rsp_type pack_item(req_type r);
      rsp_type o;
      int      cell_idx;
      int      addr;
      logic [7:0] mask;
      bit      as_fg;
      bit      refused;
      o.status    = STATUS_OK;
      o.read_data = '0;
      case (r.kind)
         KIND_PIXEL: begin
            if (r.pixel_x >= SCR_W || r.pixel_y >= SCR_H) begin
               o.status = STATUS_RANGE;
            end else begin
               cell_idx = (r.pixel_y / 8) * COLS + r.pixel_x / 8;
               addr    = (r.pixel_y / 8) * SCR_W + (r.pixel_x / 8) * 8 + r.pixel_y[2:0];
               mask    = 8'h80 >> r.pixel_x[2:0];
               as_fg   = 1'b0;
               refused = 1'b0;
               case (cell_cnt[cell_idx])
                  2'd0: begin
                     cell_cnt[cell_idx] = 2'd1;
                     cell_bg[cell_idx]  = r.pixel_color;
                  end
                  2'd1: begin
                     if (cell_bg[cell_idx] != r.pixel_color) begin
                        cell_cnt[cell_idx] = 2'd2;
                        cell_fg[cell_idx]  = r.pixel_color;
                        as_fg              = 1'b1;
                     end
                  end
                  default: begin
                     if (cell_fg[cell_idx] == r.pixel_color) as_fg = 1'b1;
                     else if (cell_bg[cell_idx] != r.pixel_color) refused = 1'b1;
                  end
               endcase
               if (refused) o.status = STATUS_THIRD;
               else if (as_fg) bm_img[addr] = bm_img[addr] | mask;
               else bm_img[addr] = bm_img[addr] & ~mask;
            end
         end
         KIND_BM_READ: begin
            if (r.read_index < BM_BYTES) o.read_data = bm_img[r.read_index];
            else o.status = STATUS_RANGE;
         end
         KIND_COLOR_READ: begin
            if (r.read_index < CELLS) begin
               if (cell_cnt[r.read_index] > 0) o.read_data[3:0] = cell_bg[r.read_index];
               if (cell_cnt[r.read_index] > 1) o.read_data[7:4] = cell_fg[r.read_index];
            end else begin
               o.status = STATUS_RANGE;
            end
         end
         default: wipe_image();
      endcase
      return o;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void pick_hot_cells();
      for (int h = 0; h < HOT_CELLS; h++) begin
         hot_col[h] = $urandom_range(0, COLS - 1);
         hot_row[h] = $urandom_range(0, ROWS - 1);
         for (int k = 0; k < 3; k++) hot_pal[h][k] = 4'($urandom_range(0, 15));
      end
      // keep the right column and the bottom row of cells in play
      hot_col[0] = COLS - 1;
      hot_row[1] = ROWS - 1;
   endfunction

   // most pixels land in a few cells with three candidate colors each,
   // so cells fill up and the third-color refusal gets exercised
   function automatic req_type rand_item();
      req_type r;
      int      sel;
      int      h;
      sel           = $urandom_range(0, 999);
      h             = $urandom_range(0, HOT_CELLS - 1);
      r.kind        = KIND_PIXEL;
      r.pixel_x     = 9'($urandom_range(0, 511));
      r.pixel_y     = 8'($urandom_range(0, 255));
      r.pixel_color = 4'($urandom_range(0, 15));
      r.read_index  = 13'($urandom_range(0, 8191));
      if (sel < 560) begin
         r.pixel_x     = 9'(hot_col[h] * 8 + $urandom_range(0, 7));
         r.pixel_y     = 8'(hot_row[h] * 8 + $urandom_range(0, 7));
         r.pixel_color = hot_pal[h][$urandom_range(0, 2)];
      end else if (sel < 640) begin
         r.kind = KIND_PIXEL;
      end else if (sel < 820) begin
         r.kind = KIND_BM_READ;
         if ($urandom_range(0, 9) < 7)
            r.read_index = 13'(hot_row[h] * SCR_W + hot_col[h] * 8 + $urandom_range(0, 7));
      end else if (sel < 993) begin
         r.kind = KIND_COLOR_READ;
         sel    = $urandom_range(0, 9);
         if (sel < 6) r.read_index = 13'(hot_row[h] * COLS + hot_col[h]);
         else if (sel < 8) r.read_index = 13'($urandom_range(0, CELLS - 1));
      end else begin
         r.kind = KIND_CLEAR;
      end
      return r;
   endfunction

   task automatic add_row(kind_type k, int x, int y, int c, int idx,
                          bit fixed, status_type st, int d);
      dir_row_type row;
      row.req.kind           = k;
      row.req.pixel_x        = 9'(x);
      row.req.pixel_y        = 8'(y);
      row.req.pixel_color    = 4'(c);
      row.req.read_index     = 13'(idx);
      row.fixed              = fixed;
      row.want.status        = st;
      row.want.read_data     = 8'(d);
      dir_rows.push_back(row);
   endtask

   // offer one item, hold it until taken, then record its response
   task automatic send_item(req_type r, bit fixed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = pack_item(r);
      rsp_awaited.push_back(fixed ? want : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (rsp_awaited.size() != 0);
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      int n;
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_LEN) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            n = 1 + idle_gap();
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_awaited.size() == 0) begin
            $display("%0t: rsp item with none awaited: status=%0d data=%02h",
                     $time, rsp_payload.status, rsp_payload.read_data);
            mismatches++;
         end else begin
            want = rsp_awaited.pop_front();
            if (rsp_payload.status != want.status) begin
               $display("%0t: status expected %0d got %0d",
                        $time, want.status, rsp_payload.status);
               mismatches++;
            end
            if (rsp_payload.read_data != want.read_data) begin
               $display("%0t: read_data expected %02h got %02h",
                        $time, want.read_data, rsp_payload.read_data);
               mismatches++;
            end
         end
      end
   end

   // reset and clear sweeps take a full image pass with no handshakes
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
         $display("%0t: no item moved for %0d cycles", $time, WDOG_MAX);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wipe_image();
      add_row(KIND_BM_READ,      0,   0,  0,    0, 1, STATUS_OK,    0);
      add_row(KIND_COLOR_READ,   0,   0,  0,    0, 1, STATUS_OK,    0);
      add_row(KIND_BM_READ,      0,   0,  0, 7999, 1, STATUS_OK,    0);
      add_row(KIND_BM_READ,      0,   0,  0, 8000, 1, STATUS_RANGE, 0);
      add_row(KIND_BM_READ,      0,   0,  0, 8191, 1, STATUS_RANGE, 0);
      add_row(KIND_COLOR_READ,   0,   0,  0,  999, 1, STATUS_OK,    0);
      add_row(KIND_COLOR_READ,   0,   0,  0, 1000, 1, STATUS_RANGE, 0);
      add_row(KIND_COLOR_READ,   0,   0,  0, 8191, 1, STATUS_RANGE, 0);
      add_row(KIND_PIXEL,      320,   0,  1,    0, 1, STATUS_RANGE, 0);
      add_row(KIND_PIXEL,        0, 200,  1,    0, 1, STATUS_RANGE, 0);
      add_row(KIND_PIXEL,      511, 255, 15, 8191, 1, STATUS_RANGE, 0);
      add_row(KIND_PIXEL,        0,   0,  5,    0, 1, STATUS_OK,    0);
      add_row(KIND_PIXEL,        7,   0,  9,    0, 1, STATUS_OK,    0);
      add_row(KIND_PIXEL,        1,   0,  3,    0, 1, STATUS_THIRD, 0);
      // rewrite the first pixel in the foreground color
      add_row(KIND_PIXEL,        0,   0,  9,    0, 0, STATUS_OK,    0);
      add_row(KIND_BM_READ,      0,   0,  0,    0, 0, STATUS_OK,    0);
      add_row(KIND_COLOR_READ,   0,   0,  0,    0, 0, STATUS_OK,    0);
      add_row(KIND_PIXEL,      319, 199, 15,    0, 0, STATUS_OK,    0);
      add_row(KIND_PIXEL,      319, 199,  0,    0, 0, STATUS_OK,    0);
      add_row(KIND_BM_READ,      0,   0,  0, 7999, 0, STATUS_OK,    0);
      add_row(KIND_COLOR_READ,   0,   0,  0,  999, 0, STATUS_OK,    0);
      add_row(KIND_CLEAR,        0,   0,  0,    0, 1, STATUS_OK,    0);
      add_row(KIND_COLOR_READ,   0,   0,  0,    0, 1, STATUS_OK,    0);
      add_row(KIND_BM_READ,      0,   0,  0,    0, 1, STATUS_OK,    0);
      add_row(KIND_COLOR_READ,   0,   0,  0,  999, 1, STATUS_OK,    0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) send_item(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].want);
      drain();

      for (int p = 0; p < 7; p++) begin
         pick_hot_cells();
         quiet = (p == 2 || p == 5);
         // back-to-back items against a long receiver hold-off
         if (p == 2) hold_off_req = 1'b1;
         if (p == 4) drain();
         for (int i = 0; i < 250; i++) send_item(rand_item(), 1'b0, '0);
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[hires_cell_bitmap_packer_top.f]
rtl/hcbp_pkg.sv
rtl/hcbp_store.sv
rtl/hires_cell_bitmap_packer_top.sv
verif/tb_top.sv
